// File: rtl/core/scope_min_max_column_renderer_macros.svh
// Assertion macros shared by the row mapper and the sequencer.
// The modules that use them have ports or signals named clk and arst_n.
`ifndef SCOPE_MIN_MAX_COLUMN_RENDERER_MACROS_SVH
`define SCOPE_MIN_MAX_COLUMN_RENDERER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMMCR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMMCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/smmcr_pkg.sv
// Package of the min/max column renderer: sizes, codes, types and state encodings.
// Used by every other file of the block but the assertion macros header.
`timescale 1ns / 1ps

package smmcr_pkg;

	localparam int COLUMNS       = 1024;
	localparam int COL_BITS      = $clog2(COLUMNS);
	localparam int SAMPLE_BITS   = 16;
	localparam int LIMIT_BITS    = SAMPLE_BITS - 1;
	localparam int DIV_BITS      = LIMIT_BITS + 1;
	localparam int ROW_BITS      = 12;
	localparam int MAX_ROWS      = 4096;
	localparam int NUM_BITS      = ROW_BITS + SAMPLE_BITS;
	localparam int DIV_STEP_BITS = 2;
	localparam int DIV_STEPS     = ROW_BITS / DIV_STEP_BITS;
	localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);
	localparam int MODE_BITS     = 2;

	localparam int SPC_BITS      = 16;
	localparam int HEIGHT_BITS   = 13;
	localparam int WIDTH_BITS    = COL_BITS + 1;

	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;

	localparam int SPC_RESET     = 8;
	localparam int LIMIT_RESET   = 32767;
	localparam int CONNECT_RESET = 1;
	localparam int HEIGHT_RESET  = 256;
	localparam int WIDTH_RESET   = 1024;

	typedef logic signed [SAMPLE_BITS-1:0] amp_t;
	typedef logic [ROW_BITS-1:0]           row_t;
	typedef logic [COL_BITS-1:0]           col_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_SAMPLE  = 2'd0,
		MODE_RESTART = 2'd1,
		MODE_RENDER  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_SPC     = 3'd0,
		REG_LIMIT   = 3'd1,
		REG_CONNECT = 3'd2,
		REG_HEIGHT  = 3'd3,
		REG_WIDTH   = 3'd4
	} reg_index_t;

	// Slots of the values that a render item maps to rows.
	localparam int VAL_SLOTS = 4;
	localparam logic [1:0] SLOT_CONN_A = 2'd0;
	localparam logic [1:0] SLOT_CONN_B = 2'd1;
	localparam logic [1:0] SLOT_MIN    = 2'd2;
	localparam logic [1:0] SLOT_MAX    = 2'd3;

	typedef struct packed {
		amp_t cmax;
		amp_t cmin;
	} col_entry_t;

	typedef struct packed {
		logic       we;
		logic       re;
		col_t       addr;
		col_entry_t wdata;
	} mem_req_t;

	// Effective configuration, with out-of-range register values already folded.
	typedef struct packed {
		logic [SPC_BITS-1:0]   spc;
		logic [LIMIT_BITS-1:0] lim;
		logic                  connect;
		row_t                  hm1;
		logic [WIDTH_BITS-1:0] width;
	} cfg_t;

	typedef struct packed {
		logic start;
		amp_t value;
	} rm_req_t;

	typedef struct packed {
		logic done;
		row_t row;
	} rm_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SMP,
		S_SMP_FOLD,
		S_RESTART,
		S_RD_CUR,
		S_GOT_CUR,
		S_GOT_PREV,
		S_MAP_START,
		S_MAP_WAIT,
		S_EMIT_CONN,
		S_EMIT_FINAL
	} seq_state_t;

	typedef enum logic [1:0] {
		RM_IDLE,
		RM_CHECK,
		RM_DIV,
		RM_DONE
	} rm_state_t;

endpackage

// File: rtl/core/smmcr_in_if.sv
// Input channel of the column renderer: valid/ready with one item per transfer.
// Depends on smmcr_pkg.
`timescale 1ns / 1ps

interface smmcr_in_if
	import smmcr_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [MODE_BITS-1:0] mode;
	amp_t                 sample;
	col_t                 column;

	modport source(output valid, mode, sample, column, input ready);
	modport sink(input valid, mode, sample, column, output ready);
endinterface

// File: rtl/core/smmcr_out_if.sv
// Output channel of the column renderer: one vertical segment per transfer.
// Depends on smmcr_pkg.
`timescale 1ns / 1ps

interface smmcr_out_if
	import smmcr_pkg::*;
();
	logic valid;
	logic ready;
	col_t seg_column;
	row_t seg_y_start;
	row_t seg_y_end;
	logic last;

	modport source(output valid, seg_column, seg_y_start, seg_y_end, last, input ready);
	modport sink(input valid, seg_column, seg_y_start, seg_y_end, last, output ready);
endinterface

// File: rtl/core/smmcr_cfg_regs.sv
// APB register file of the column renderer and the effective configuration derived from it.
// Depends on smmcr_pkg.
`timescale 1ns / 1ps

module smmcr_cfg_regs
	import smmcr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	logic [SPC_BITS-1:0]    spc_q;
	logic [LIMIT_BITS-1:0]  limit_q;
	logic                   connect_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [WIDTH_BITS-1:0]  width_q;
	logic [2:0]             index;
	logic                   wr;
	logic [HEIGHT_BITS-1:0] height_m1;

	assign pready = 1'b1;
	assign index  = paddr[APB_ADDR_BITS-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q     <= SPC_BITS'(SPC_RESET);
			limit_q   <= LIMIT_BITS'(LIMIT_RESET);
			connect_q <= 1'(CONNECT_RESET);
			height_q  <= HEIGHT_BITS'(HEIGHT_RESET);
			width_q   <= WIDTH_BITS'(WIDTH_RESET);
		end else if (wr) begin
			case (index)
				REG_SPC:     spc_q     <= pwdata[SPC_BITS-1:0];
				REG_LIMIT:   limit_q   <= pwdata[LIMIT_BITS-1:0];
				REG_CONNECT: connect_q <= pwdata[0];
				REG_HEIGHT:  height_q  <= pwdata[HEIGHT_BITS-1:0];
				REG_WIDTH:   width_q   <= pwdata[WIDTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_SPC:     prdata = APB_DATA_BITS'(spc_q);
			REG_LIMIT:   prdata = APB_DATA_BITS'(limit_q);
			REG_CONNECT: prdata = APB_DATA_BITS'(connect_q);
			REG_HEIGHT:  prdata = APB_DATA_BITS'(height_q);
			REG_WIDTH:   prdata = APB_DATA_BITS'(width_q);
			default:     prdata = '0;
		endcase
	end

	assign height_m1 = height_q - HEIGHT_BITS'(1);

	always_comb begin
		cfg.spc     = (spc_q == '0) ? SPC_BITS'(1) : spc_q;
		cfg.lim     = (limit_q == '0) ? LIMIT_BITS'(1) : limit_q;
		cfg.connect = connect_q;
		// A height below two rows maps everything to row 0, which a zero scale gives.
		if (height_q < HEIGHT_BITS'(2)) begin
			cfg.hm1 = '0;
		end else if (height_q > HEIGHT_BITS'(MAX_ROWS)) begin
			cfg.hm1 = ROW_BITS'(MAX_ROWS - 1);
		end else begin
			cfg.hm1 = height_m1[ROW_BITS-1:0];
		end
		if (width_q == '0) begin
			cfg.width = WIDTH_BITS'(1);
		end else if (width_q > WIDTH_BITS'(COLUMNS)) begin
			cfg.width = WIDTH_BITS'(COLUMNS);
		end else begin
			cfg.width = width_q;
		end
	end

endmodule

// File: rtl/core/smmcr_col_store.sv
// Column min/max memory: one synchronous RAM of max/min pairs with a registered read port.
// After reset it sweeps every entry to its reset value. Depends on smmcr_pkg.
`timescale 1ns / 1ps

module smmcr_col_store
	import smmcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output col_entry_t rdata,
	output logic       busy
);

	col_entry_t mem [COLUMNS];
	logic       clearing_q;
	col_t       clr_addr_q;
	col_entry_t clr_entry;

	// Column 0 starts opened at the reset limit, all others start at zero.
	always_comb begin
		if (clr_addr_q == '0) begin
			clr_entry.cmax = -amp_t'(LIMIT_RESET);
			clr_entry.cmin = amp_t'(LIMIT_RESET);
		end else begin
			clr_entry = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + COL_BITS'(1);
			if (clr_addr_q == COL_BITS'(COLUMNS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= clr_entry;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

	assign busy = clearing_q;

endmodule

// File: rtl/core/smmcr_row_map.sv
// Row mapper: y = min(hm1, (hm1 * (v + lim)) / (2 * lim)), zero for non-positive numerators.
// A registered multiply, a range check, then a radix-4 restoring divider. Depends on smmcr_pkg.
`timescale 1ns / 1ps
`include "scope_min_max_column_renderer_macros.svh"

module smmcr_row_map
	import smmcr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  rm_req_t req,
	output rm_rsp_t rsp
);

	rm_state_t state_q, state_d;

	logic [NUM_BITS-1:0]      num_q;
	logic [DIV_BITS-1:0]      rem_q;
	logic [ROW_BITS-1:0]      low_q;
	row_t                     quo_q;
	row_t                     row_q;
	logic [STEP_CNT_BITS-1:0] cnt_q;

	logic [DIV_BITS-1:0]      divisor;
	logic [SAMPLE_BITS:0]     sum;
	logic                     sum_pos;
	logic [NUM_BITS-1:0]      product;
	logic [DIV_BITS-1:0]      num_hi;
	logic                     clamp;
	logic [DIV_BITS-1:0]      rem_d;
	logic [DIV_STEP_BITS-1:0] qbits;
	row_t                     quo_d;
	logic                     last_step;

	assign divisor = {cfg.lim, 1'b0};
	assign sum     = {req.value[SAMPLE_BITS-1], req.value} + {2'b00, cfg.lim};
	assign sum_pos = !sum[SAMPLE_BITS] && (sum[SAMPLE_BITS-1:0] != '0);
	assign product = NUM_BITS'(cfg.hm1) * NUM_BITS'(sum[SAMPLE_BITS-1:0]);

	// A high part at or above the divisor means a quotient of at least 2^ROW_BITS.
	assign num_hi = num_q[NUM_BITS-1:ROW_BITS];
	assign clamp  = num_hi >= divisor;

	always_comb begin
		logic [DIV_BITS:0] trial;
		rem_d = rem_q;
		qbits = '0;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			trial = {rem_d, low_q[ROW_BITS-1-i]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				qbits[DIV_STEP_BITS-1-i] = 1'b1;
			end
			rem_d = trial[DIV_BITS-1:0];
		end
	end

	assign quo_d     = {quo_q[ROW_BITS-DIV_STEP_BITS-1:0], qbits};
	assign last_step = cnt_q == STEP_CNT_BITS'(DIV_STEPS - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			RM_IDLE:  if (req.start) state_d = RM_CHECK;
			RM_CHECK: state_d = clamp ? RM_DONE : RM_DIV;
			RM_DIV:   if (last_step) state_d = RM_DONE;
			RM_DONE:  state_d = RM_IDLE;
			default:  state_d = RM_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = state_q == RM_DONE;
		rsp.row  = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == RM_CHECK) begin
				cnt_q <= '0;
			end else if (state_q == RM_DIV) begin
				cnt_q <= cnt_q + STEP_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			RM_IDLE: begin
				if (req.start) begin
					num_q <= sum_pos ? product : '0;
				end
			end
			RM_CHECK: begin
				rem_q <= num_hi;
				low_q <= num_q[ROW_BITS-1:0];
				quo_q <= '0;
				if (clamp) begin
					row_q <= cfg.hm1;
				end
			end
			RM_DIV: begin
				rem_q <= rem_d;
				low_q <= low_q << DIV_STEP_BITS;
				quo_q <= quo_d;
				if (last_step) begin
					row_q <= (quo_d > cfg.hm1) ? cfg.hm1 : quo_d;
				end
			end
			default: ;
		endcase
	end

	`SMMCR_ASSERT_NOW(a_start_when_idle, req.start, state_q == RM_IDLE, "row map started while busy")
	`SMMCR_ASSERT_NOW(a_rem_below_div, state_q == RM_DIV, rem_q < divisor, "divider remainder overflow")
	`SMMCR_ASSERT_NOW(a_row_in_range, rsp.done, rsp.row <= cfg.hm1, "mapped row beyond display")

endmodule

// File: rtl/core/smmcr_seq.sv
// Sequencer of the column renderer: opens columns, folds samples into them by
// read-modify-write, walks render items through the row mapper and emits segments.
// Depends on smmcr_pkg, smmcr_in_if and smmcr_out_if.
`timescale 1ns / 1ps
`include "scope_min_max_column_renderer_macros.svh"

module smmcr_seq
	import smmcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	smmcr_in_if.sink   item,
	smmcr_out_if.source seg,
	output mem_req_t   mem_req,
	input  col_entry_t mem_rdata,
	input  logic       mem_busy,
	output rm_req_t    rm_req,
	input  rm_rsp_t    rm_rsp
);

	seq_state_t state_q, state_d;

	col_t                cursor_q;
	logic [SPC_BITS-1:0] left_q;
	amp_t                samp_q;
	col_t                col_q;
	amp_t                vals_q [VAL_SLOTS];
	row_t                rows_q [VAL_SLOTS];
	logic [1:0]          idx_q;
	logic                conn_q;

	logic out_valid_q;
	col_t out_col_q;
	row_t out_y0_q;
	row_t out_y1_q;
	logic out_last_q;

	logic                accept;
	logic                out_free;
	logic                out_load;
	col_t                prev_col;
	logic                need_prev;
	logic [COL_BITS:0]   nx_wide;
	col_t                nx_col;
	amp_t                pos_lim;
	amp_t                neg_lim;
	logic                pmx_below;
	logic                pmn_above;
	logic                gap;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || seg.ready;
	assign prev_col = col_q - COL_BITS'(1);
	assign nx_wide  = {1'b0, cursor_q} + (COL_BITS + 1)'(1);
	assign nx_col   = (nx_wide >= cfg.width) ? '0 : nx_wide[COL_BITS-1:0];
	assign pos_lim  = amp_t'({1'b0, cfg.lim});
	assign neg_lim  = -pos_lim;

	// The neighbor is left out at column 0 and where the cursor is still filling it.
	assign need_prev = cfg.connect && (col_q != '0) && (cursor_q != prev_col);
	assign pmx_below = mem_rdata.cmax < vals_q[SLOT_MIN];
	assign pmn_above = mem_rdata.cmin > vals_q[SLOT_MAX];
	assign gap       = pmx_below || pmn_above;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_SAMPLE:  state_d = S_SMP;
						MODE_RESTART: state_d = S_RESTART;
						MODE_RENDER:  state_d = S_RD_CUR;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_SMP:       state_d = (left_q == '0) ? S_IDLE : S_SMP_FOLD;
			S_SMP_FOLD:  state_d = S_IDLE;
			S_RESTART:   state_d = S_IDLE;
			S_RD_CUR:    state_d = S_GOT_CUR;
			S_GOT_CUR:   state_d = need_prev ? S_GOT_PREV : S_MAP_START;
			S_GOT_PREV:  state_d = S_MAP_START;
			S_MAP_START: state_d = S_MAP_WAIT;
			S_MAP_WAIT: begin
				if (rm_rsp.done) begin
					if (idx_q == SLOT_MAX) begin
						state_d = conn_q ? S_EMIT_CONN : S_EMIT_FINAL;
					end else begin
						state_d = S_MAP_START;
					end
				end
			end
			S_EMIT_CONN:  if (out_free) state_d = S_EMIT_FINAL;
			S_EMIT_FINAL: if (out_free) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// One item is in flight at a time, so a write always lands before the next read
	// of the same entry and no forwarding is needed.
	always_comb begin
		item.ready   = (state_q == S_IDLE) && !mem_busy;
		mem_req      = '0;
		rm_req.start = 1'b0;
		rm_req.value = vals_q[idx_q];
		out_load     = 1'b0;
		case (state_q)
			S_SMP: begin
				if (left_q == '0) begin
					mem_req.we         = 1'b1;
					mem_req.addr       = nx_col;
					mem_req.wdata.cmax = (samp_q > neg_lim) ? samp_q : neg_lim;
					mem_req.wdata.cmin = (samp_q < pos_lim) ? samp_q : pos_lim;
				end else begin
					mem_req.re   = 1'b1;
					mem_req.addr = cursor_q;
				end
			end
			S_SMP_FOLD: begin
				mem_req.we         = 1'b1;
				mem_req.addr       = cursor_q;
				mem_req.wdata.cmax = (samp_q > mem_rdata.cmax) ? samp_q : mem_rdata.cmax;
				mem_req.wdata.cmin = (samp_q < mem_rdata.cmin) ? samp_q : mem_rdata.cmin;
			end
			S_RESTART: begin
				mem_req.we         = 1'b1;
				mem_req.addr       = '0;
				mem_req.wdata.cmax = neg_lim;
				mem_req.wdata.cmin = pos_lim;
			end
			S_RD_CUR: begin
				mem_req.re   = 1'b1;
				mem_req.addr = col_q;
			end
			S_GOT_CUR: begin
				mem_req.re   = need_prev;
				mem_req.addr = prev_col;
			end
			S_MAP_START:  rm_req.start = 1'b1;
			S_EMIT_CONN:  out_load = out_free;
			S_EMIT_FINAL: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			left_q      <= SPC_BITS'(SPC_RESET);
			idx_q       <= SLOT_MIN;
			conn_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_SMP: begin
					if (left_q == '0) begin
						cursor_q <= nx_col;
						left_q   <= cfg.spc - SPC_BITS'(1);
					end
				end
				S_SMP_FOLD: left_q <= left_q - SPC_BITS'(1);
				S_RESTART: begin
					cursor_q <= '0;
					left_q   <= cfg.spc;
				end
				S_GOT_CUR: begin
					conn_q <= 1'b0;
					idx_q  <= SLOT_MIN;
				end
				S_GOT_PREV: begin
					conn_q <= gap;
					idx_q  <= gap ? SLOT_CONN_A : SLOT_MIN;
				end
				S_MAP_WAIT: begin
					if (rm_rsp.done && idx_q != SLOT_MAX) begin
						idx_q <= idx_q + 2'd1;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (seg.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= item.sample;
			col_q  <= item.column;
		end
		case (state_q)
			S_GOT_CUR: begin
				vals_q[SLOT_MIN] <= mem_rdata.cmin;
				vals_q[SLOT_MAX] <= mem_rdata.cmax;
			end
			S_GOT_PREV: begin
				if (pmx_below) begin
					vals_q[SLOT_CONN_A] <= mem_rdata.cmax;
					vals_q[SLOT_CONN_B] <= vals_q[SLOT_MIN];
				end else begin
					vals_q[SLOT_CONN_A] <= mem_rdata.cmin;
					vals_q[SLOT_CONN_B] <= vals_q[SLOT_MAX];
				end
			end
			S_MAP_WAIT: begin
				if (rm_rsp.done) begin
					rows_q[idx_q] <= rm_rsp.row;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			if (state_q == S_EMIT_CONN) begin
				out_col_q  <= prev_col;
				out_y0_q   <= rows_q[SLOT_CONN_A];
				out_y1_q   <= rows_q[SLOT_CONN_B];
				out_last_q <= 1'b0;
			end else begin
				out_col_q  <= col_q;
				out_y0_q   <= rows_q[SLOT_MIN];
				out_y1_q   <= rows_q[SLOT_MAX];
				out_last_q <= 1'b1;
			end
		end
	end

	assign seg.valid       = out_valid_q;
	assign seg.seg_column  = out_col_q;
	assign seg.seg_y_start = out_y0_q;
	assign seg.seg_y_end   = out_y1_q;
	assign seg.last        = out_last_q;

	`SMMCR_ASSERT_NOW(a_mem_idle, mem_req.we || mem_req.re, state_q != S_IDLE, "memory access in idle")
	`SMMCR_ASSERT_NOW(a_rm_done_wait, rm_rsp.done, state_q == S_MAP_WAIT, "row result not awaited")
	`SMMCR_ASSERT_NOW(a_conn_then_final, out_valid_q && !out_last_q, state_q == S_EMIT_FINAL, "connecting segment without final segment")

endmodule

// File: rtl/core/scope_min_max_column_renderer.sv
// Oscilloscope min/max column renderer, top level.
// Sample items pass through S_SMP, and S_SMP_FOLD too when folding into an open column;
// restart items pass through S_RESTART. Render items map two rows, four with a connecting
// segment, one after another in the shared radix-4 row divider, which skips the division
// for a clamped row. After reset a clearing pass sweeps the column memory; no item is taken
// until it ends, while configuration writes are taken at once.
`timescale 1ns / 1ps

module scope_min_max_column_renderer
	import smmcr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	smmcr_in_if.sink                 item,
	smmcr_out_if.source              seg
);

	cfg_t       cfg;
	mem_req_t   mem_req;
	col_entry_t mem_rdata;
	logic       mem_busy;
	rm_req_t    rm_req;
	rm_rsp_t    rm_rsp;

	smmcr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smmcr_col_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	smmcr_row_map u_row_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (rm_req),
		.rsp    (rm_rsp)
	);

	smmcr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.seg       (seg),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.mem_busy  (mem_busy),
		.rm_req    (rm_req),
		.rm_rsp    (rm_rsp)
	);

endmodule

// File: verif/segment_checker.sv
// Checker for the min/max column renderer: follows register writes and item transfers,
// predicts the segments that each render item should draw and compares them in order.
// Depends on smmcr_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module segment_checker
	import smmcr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic                     pready,
	smmcr_in_if                      items,
	smmcr_out_if                     segs,
	output int                       mismatches,
	output int                       segs_pending,
	output int                       segs_compared
);

	typedef struct {
		col_t column;
		row_t y_start;
		row_t y_end;
		logic last;
	} segment_t;

	segment_t segs_due[$];

	int unsigned spc_reg, lim_reg, connect_reg, height_reg, width_reg;
	int unsigned cursor, samples_left;
	int col_max[COLUMNS];
	int col_min[COLUMNS];

	function automatic int lim_eff();
		return (lim_reg == 0) ? 1 : int'(lim_reg);
	endfunction

	function automatic int unsigned spc_eff();
		return (spc_reg == 0) ? 1 : spc_reg;
	endfunction

	// Exact integer form of the row mapping, clamped to the visible rows.
	function automatic row_t row_of(int v);
		longint hm1, num, y, lim;
		lim = lim_eff();
		if (height_reg < 2)
			return '0;
		hm1 = longint'((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg) - 1;
		num = hm1 * (longint'(v) + lim);
		if (num <= 0)
			return '0;
		y = num / (2 * lim);
		if (y > hm1)
			y = hm1;
		return row_t'(y);
	endfunction

	task automatic open_column(int unsigned c);
		col_max[c] = -lim_eff();
		col_min[c] = lim_eff();
	endtask

	task automatic fold_sample(amp_t s);
		int unsigned next_col, width_eff;
		int v;
		v = s;
		width_eff = (width_reg == 0) ? 1 : ((width_reg > COLUMNS) ? COLUMNS : width_reg);
		// The cursor moves on the first sample after a column is full, not on the last one.
		if (samples_left == 0) begin
			next_col = cursor + 1;
			if (next_col >= width_eff)
				next_col = 0;
			cursor = next_col;
			open_column(cursor);
			samples_left = spc_eff();
		end
		if (v < col_min[cursor])
			col_min[cursor] = v;
		if (v > col_max[cursor])
			col_max[cursor] = v;
		samples_left = (samples_left - 1) & 32'h0000_FFFF;
	endtask

	task automatic render_column(col_t x);
		int hi, lo, prev_hi, prev_lo;
		hi = col_max[x];
		lo = col_min[x];
		// No bridge is drawn from the column that is still being filled.
		if (connect_reg != 0 && x != 0 && cursor != x - 1) begin
			prev_hi = col_max[x - 1];
			prev_lo = col_min[x - 1];
			if (prev_hi < lo)
				segs_due.push_back('{col_t'(x - 1), row_of(prev_hi), row_of(lo), 1'b0});
			else if (prev_lo > hi)
				segs_due.push_back('{col_t'(x - 1), row_of(prev_lo), row_of(hi), 1'b0});
		end
		segs_due.push_back('{x, row_of(lo), row_of(hi), 1'b1});
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		segment_t want;
		if (!arst_n) begin
			spc_reg = SPC_RESET;
			lim_reg = LIMIT_RESET;
			connect_reg = CONNECT_RESET;
			height_reg = HEIGHT_RESET;
			width_reg = WIDTH_RESET;
			for (int i = 0; i < COLUMNS; i++) begin
				col_max[i] = 0;
				col_min[i] = 0;
			end
			col_max[0] = -LIMIT_RESET;
			col_min[0] = LIMIT_RESET;
			cursor = 0;
			samples_left = SPC_RESET;
			segs_due.delete();
			mismatches = 0;
			segs_compared = 0;
			segs_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_BITS-1:2])
					REG_SPC:     spc_reg = pwdata[SPC_BITS-1:0];
					REG_LIMIT:   lim_reg = pwdata[LIMIT_BITS-1:0];
					REG_CONNECT: connect_reg = pwdata[0];
					REG_HEIGHT:  height_reg = pwdata[HEIGHT_BITS-1:0];
					REG_WIDTH:   width_reg = pwdata[WIDTH_BITS-1:0];
					default: ;
				endcase
			end
			if (items.valid && items.ready) begin
				case (items.mode)
					MODE_SAMPLE: fold_sample(items.sample);
					MODE_RESTART: begin
						cursor = 0;
						samples_left = spc_eff();
						open_column(0);
					end
					MODE_RENDER: render_column(items.column);
					default: ;
				endcase
			end
			if (segs.valid && segs.ready) begin
				if (segs_due.size() == 0) begin
					mismatches++;
					$error("segment transfer with nothing expected: column %0d, rows %0d..%0d",
						segs.seg_column, segs.seg_y_start, segs.seg_y_end);
				end else begin
					want = segs_due.pop_front();
					check_field("seg_column", want.column, segs.seg_column);
					check_field("seg_y_start", want.y_start, segs.seg_y_start);
					check_field("seg_y_end", want.y_end, segs.seg_y_end);
					check_field("last", want.last, segs.last);
					segs_compared++;
				end
			end
			segs_pending <= segs_due.size();
		end
	end

endmodule

// File: verif/testbench.sv
// Top of the column renderer testbench: clock, reset, register programming and item stimulus.
// Depends on smmcr_pkg, the channel interfaces, the renderer and segment_checker.
`timescale 1ns / 1ps

module testbench;
	import smmcr_pkg::*;

	localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 64;
	localparam int NEAR_COLUMNS = 64;
	localparam int DIRECTED_SAMPLES [9] = '{-32768, 32767, 0, -1, 1, 16384, -16384, 5, 12000};

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int idle_pct;
	int stall_pct;
	int mismatches;
	int segs_pending;
	int segs_compared;
	int samples_sent;
	int restarts_sent;
	int renders_sent;
	int unused_sent;

	smmcr_in_if  item_ch ();
	smmcr_out_if seg_ch ();

	scope_min_max_column_renderer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.seg     (seg_ch)
	);

	segment_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.items         (item_ch),
		.segs          (seg_ch),
		.mismatches    (mismatches),
		.segs_pending  (segs_pending),
		.segs_compared (segs_compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		seg_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic write_reg(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Returns at the edge where the item transfer took place.
	task automatic send_item(logic [MODE_BITS-1:0] mode, amp_t value, col_t col);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= mode;
		item_ch.sample <= value;
		item_ch.column <= col;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		case (mode)
			MODE_SAMPLE:  samples_sent++;
			MODE_RESTART: restarts_sent++;
			MODE_RENDER:  renders_sent++;
			default:      unused_sent++;
		endcase
	endtask

	task automatic drain(int settle);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (segs_pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		int p, r, done, lim_eff, w_eff, near;
		int spc, lim, conn, height, width;
		amp_t value;
		col_t col;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_SAMPLE;
		item_ch.sample = '0;
		item_ch.column = '0;
		idle_pct = 0;
		stall_pct = 0;
		samples_sent = 0;
		restarts_sent = 0;
		renders_sent = 0;
		unused_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the reset contents of columns 0 to 2, the unused code,
		// samples at both ends of the range, a move to the next column, a restart
		// and a gap between neighboring columns.
		send_item(MODE_RENDER, '0, col_t'(0));
		send_item(MODE_RENDER, '0, col_t'(1));
		send_item(MODE_RENDER, '0, col_t'(2));
		send_item(MODE_UNUSED, '1, '1);
		for (int i = 0; i < 9; i++)
			send_item(MODE_SAMPLE, amp_t'(DIRECTED_SAMPLES[i]), '0);
		send_item(MODE_RENDER, '0, col_t'(0));
		send_item(MODE_RENDER, '0, col_t'(1));
		send_item(MODE_RENDER, '0, col_t'(2));
		send_item(MODE_RESTART, '0, '0);
		send_item(MODE_RENDER, '0, col_t'(2));
		send_item(MODE_RENDER, '0, col_t'(1));
		send_item(MODE_SAMPLE, amp_t'(20000), '0);
		send_item(MODE_RENDER, '0, col_t'(COLUMNS - 1));
		drain(SETTLE_CYCLES);

		for (p = 1; p <= PHASES; p++) begin
			case (p)
				1: begin spc = 1;     lim = 32767; conn = 1; height = 4096; width = 1024; end
				2: begin spc = 3;     lim = 1000;  conn = 1; height = 100;  width = 16;   end
				3: begin spc = 0;     lim = 0;     conn = 1; height = 0;    width = 0;    end
				4: begin spc = 65535; lim = 1;     conn = 0; height = 8191; width = 2047; end
				5: begin spc = 2;     lim = 32767; conn = 1; height = 1;    width = 8;    end
				6: begin spc = 1;     lim = 50;    conn = 1; height = 2;    width = 4;    end
				default: begin
					spc = $urandom_range(1, 4);
					lim = $urandom_range(0, 1) ? $urandom_range(1, 32767) : $urandom_range(1, 200);
					conn = $urandom_range(0, 1);
					height = $urandom_range(2, MAX_ROWS);
					width = $urandom_range(1, 32);
				end
			endcase
			write_reg(REG_SPC, spc);
			write_reg(REG_LIMIT, lim);
			write_reg(REG_CONNECT, conn);
			write_reg(REG_HEIGHT, height);
			write_reg(REG_WIDTH, width);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;

			lim_eff = (lim == 0) ? 1 : lim;
			w_eff = (width == 0) ? 1 : ((width > COLUMNS) ? COLUMNS : width);
			near = (w_eff > NEAR_COLUMNS) ? NEAR_COLUMNS : w_eff;
			case (p % 4)
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				3: begin idle_pct = 9;  stall_pct = 9;  end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase

			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				value = amp_t'($urandom());
				col = col_t'($urandom());
				if (r < 4) begin
					send_item(MODE_UNUSED, value, col);
				end else if (r < 8) begin
					send_item(MODE_RESTART, value, col);
				end else if (r < 60) begin
					// Bias toward the limit and just past it, where the row clamps act.
					case ($urandom_range(0, 9))
						0: value = amp_t'(-32768);
						1: value = amp_t'(32767);
						2: value = amp_t'(lim_eff);
						3: value = amp_t'(-lim_eff);
						4: value = amp_t'(lim_eff + 1);
						5: value = amp_t'(-lim_eff - 1);
						6, 7: value = amp_t'(int'($urandom_range(0, 2 * lim_eff)) - lim_eff);
						default: ;
					endcase
					send_item(MODE_SAMPLE, value, col);
				end else begin
					// Mostly columns near the start of the display, where the cursor works.
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: col = col_t'($urandom_range(0, near - 1));
						6: col = '0;
						7: col = col_t'((w_eff < COLUMNS) ? w_eff : COLUMNS - 1);
						8: col = col_t'(w_eff - 1);
						default: ;
					endcase
					send_item(MODE_RENDER, value, col);
				end
				if (r >= 4)
					done++;
			end
			drain((p == PHASES) ? TAIL_CYCLES : SETTLE_CYCLES);
		end

		$display("Sent %0d sample, %0d restart, %0d render and %0d unused-code items over %0d settings.",
			samples_sent, restarts_sent, renders_sent, unused_sent, PHASES + 1);
		$display("Compared %0d segments; %0d mismatches.", segs_compared, mismatches);
		if (mismatches == 0 && segs_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
